### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/srr_pkg.sv
// Shared types, constants and tables of the stamp rotation renderer.
// Depends on nothing; imported by every module of the block.
package srr_pkg;

   localparam int WordRamBytes = 262144;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  reg_index;
      logic [17:0] ram_address;
      logic [15:0] write_data;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        busy_res;
      logic        irq_pulse;
   } rsp_type;

   typedef struct packed {
      logic [1:0] priority_mode;
      logic       one_meg_mode;
      logic       irq_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_REG_WR = 3'd0,
      OP_REG_RD = 3'd1,
      OP_RAM_WR = 3'd2,
      OP_RAM_RD = 3'd3,
      OP_TICK   = 3'd4,
      OP_NOP    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      RI_STAMP_SIZE = 3'd0,
      RI_MAP_BASE   = 3'd1,
      RI_VCELL      = 3'd2,
      RI_IMG_START  = 3'd3,
      RI_IMG_OFFSET = 3'd4,
      RI_HDOT       = 3'd5,
      RI_VDOT       = 3'd6,
      RI_VECTOR     = 3'd7
   } reg_idx_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  reg_index;
      logic [17:0] ram_address;
      logic [15:0] write_data;
   } cmd_type;

   // Draw speed per line, 4.16, indexed by bits 8..3 of the dot width.
   localparam logic [19:0] SPEED_TABLE [64] = '{
      20'h54000, 20'h48000, 20'h40000, 20'h36000, 20'h2E000, 20'h28000, 20'h24000, 20'h22000,
      20'h21000, 20'h20000, 20'h1E000, 20'h1B800, 20'h19800, 20'h17A00, 20'h15C00, 20'h13E00,
      20'h12000, 20'h11800, 20'h11000, 20'h10800, 20'h10000, 20'h0F800, 20'h0F000, 20'h0E800,
      20'h0E000, 20'h0D800, 20'h0D000, 20'h0C800, 20'h0C000, 20'h0B800, 20'h0B000, 20'h0A800,
      20'h0A000, 20'h09F00, 20'h09E00, 20'h09D00, 20'h09C00, 20'h09B00, 20'h09A00, 20'h09900,
      20'h09800, 20'h09700, 20'h09600, 20'h09500, 20'h09400, 20'h09300, 20'h09200, 20'h09100,
      20'h09000, 20'h08F00, 20'h08E00, 20'h08D00, 20'h08C00, 20'h08B00, 20'h08A00, 20'h08900,
      20'h08800, 20'h08700, 20'h08600, 20'h08500, 20'h08400, 20'h08300, 20'h08200, 20'h08100
   };

endpackage

### hw/rtl/srr_front.sv
// Front end of the renderer: takes request transfers, classifies them
// and holds them in a two-entry command queue. Depends on srr_pkg.
module srr_front import srr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       take;
   op_type     op;

   always_comb begin
      unique case (req_data.mode)
         3'd0:    op = OP_REG_WR;
         3'd1:    op = OP_REG_RD;
         3'd2:    op = OP_RAM_WR;
         3'd3:    op = OP_RAM_RD;
         3'd4:    op = OP_TICK;
         default: op = OP_NOP;
      endcase
      q_in = '{op: op, reg_index: req_data.reg_index,
               ram_address: req_data.ram_address, write_data: req_data.write_data};
   end

   assign req_full  = hold || (cnt_ff == 2'd2);
   assign take      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ take;
      rp_in  = rp_ff ^ (cmd_pop && cmd_valid);
      cnt_in = cnt_ff + {1'b0, take} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wp_ff] <= q_in;
      end
   end

endmodule

### hw/rtl/srr_back.sv
// Back end of the renderer: control registers, word RAM and the line and
// pixel sequencer that carries out each command. Depends on srr_pkg.
module srr_back import srr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_room,
   output logic    rsp_push,
   output rsp_type rsp,
   output logic    clearing
);

   typedef enum logic [14:0] {
      ST_CLEAR  = 15'b000000000000001,
      ST_IDLE   = 15'b000000000000010,
      ST_RAMRD  = 15'b000000000000100,
      ST_RUN    = 15'b000000000001000,
      ST_LINE   = 15'b000000000010000,
      ST_VEC    = 15'b000000000100000,
      ST_PIX    = 15'b000000001000000,
      ST_MAP1   = 15'b000000010000000,
      ST_MAP2   = 15'b000000100000000,
      ST_STAMP0 = 15'b000001000000000,
      ST_STAMP1 = 15'b000010000000000,
      ST_BUF0   = 15'b000100000000000,
      ST_BUF1   = 15'b001000000000000,
      ST_ADV    = 15'b010000000000000,
      ST_DONE   = 15'b100000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [17:0] clr_ff, clr_in;
   logic        busy_ff, busy_in;
   logic [2:0]  ssize_ff, ssize_in;
   logic [15:0] map_base_ff, map_base_in;
   logic [4:0]  vcell_ff, vcell_in;
   logic [15:0] img_start_ff, img_start_in;
   logic [5:0]  img_off_ff, img_off_in;
   logic [8:0]  hdot_ff, hdot_in;
   logic [7:0]  vdot_ff, vdot_in;
   logic [4:0]  fn_ff, fn_in;
   logic [15:0] line_y_ff, line_y_in;
   logic [18:0] vp_ff, vp_in;
   logic [19:0] speed_ff, speed_in;
   logic [31:0] acc_ff, acc_in;
   logic [17:0] map_addr_ff, map_addr_in;
   logic [15:0] lines_ff, lines_in;
   logic [8:0]  count_ff, count_in;
   logic [2:0]  col_ff, col_in;
   logic [17:0] buf_ff, buf_in;
   logic [23:0] x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0] vec_ff, vec_in, vec_next;
   logic [3:0]  k_ff, k_in;
   logic [15:0] entry_ff, entry_in;
   logic [3:0]  pix_ff, pix_in;
   logic [15:0] rd_ff, rd_in;
   logic        irq_ff, irq_in;

   logic [7:0]  ram_mem [WordRamBytes];
   logic [7:0]  rdata_ff;
   logic        ram_we;
   logic [17:0] ram_wa, ram_ra;
   logic [7:0]  ram_wd;

   logic        prio_on, clipped, st_lo;
   logic [23:0] clip_mask;
   logic [15:0] idx;
   logic [17:0] map_rd, st_addr, buf_addr, cell_step, map_start;
   logic [31:0] xe, ye, sb, a, b, nib;
   logic [3:0]  sel;

   assign prio_on   = |fn_ff[4:3];
   assign clip_mask = fn_ff[2] ? 24'h800000 : 24'hf80000;
   assign clipped   = !fn_ff[0] && |((x_ff | y_ff) & clip_mask);
   assign map_rd    = map_addr_ff + {1'b0, idx, 1'b0};
   assign buf_addr  = buf_ff + {16'b0, col_ff[2], ~col_ff[1]};
   assign cell_step = {7'b0, ({1'b0, vcell_ff} + 6'd1), 5'b0};
   assign vec_next  = {rdata_ff, vec_ff[63:8]};

   // Map cell index for the current sample point.
   always_comb begin
      if (fn_ff[1]) begin
         idx = fn_ff[2] ? {2'b0, y_ff[22:16], x_ff[22:16]} : {10'b0, y_ff[18:16], x_ff[18:16]};
      end else begin
         idx = fn_ff[2] ? {y_ff[22:15], x_ff[22:15]} : {8'b0, y_ff[18:15], x_ff[18:15]};
      end
   end

   always_comb begin
      unique case (ssize_ff[2:1])
         2'd0:    map_start = {map_base_ff[15:7], 9'b0};
         2'd1:    map_start = {map_base_ff[15:5], 7'b0};
         2'd2:    map_start = 18'h20000;
         default: map_start = {map_base_ff[15:13], 15'b0};
      endcase
   end

   // Dot address inside the stamp, with flip and rotation applied.
   always_comb begin
      xe  = {8'b0, x_ff};
      ye  = {8'b0, y_ff};
      sb  = {14'b0, entry_ff[10:0], 7'b0};
      sel = {entry_ff[15:13], fn_ff[1]};
      b   = 32'd0;
      unique case (sel)
         4'h0: begin b = ((ye >> 9) & 32'h3c) + sb; nib = (xe & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 8) & 32'h40) + b; end
         4'h1: begin b = ((ye >> 9) & 32'h7c) + sb; nib = (xe & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 7) & 32'h180) + b; end
         4'h2: begin nib = (ye & 32'h3800) ^ 32'h2800;
                     a = ((xe >> 9) & 32'h3c) + sb + (((ye >> 8) & 32'h40) ^ 32'h40); end
         4'h3: begin nib = (ye & 32'h3800) ^ 32'h2800;
                     a = ((xe >> 9) & 32'h7c) + sb + (((ye >> 7) & 32'h180) ^ 32'h180); end
         4'h4: begin b = (((ye >> 9) & 32'h3c) ^ 32'h3c) + sb; nib = (xe & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 8) & 32'h40) ^ 32'h40) + b; end
         4'h5: begin b = (((ye >> 9) & 32'h7c) ^ 32'h7c) + sb; nib = (xe & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 7) & 32'h180) ^ 32'h180) + b; end
         4'h6: begin nib = (ye & 32'h3800) ^ 32'h1000;
                     a = (((xe >> 9) & 32'h3c) ^ 32'h3c) + sb + ((ye >> 8) & 32'h40); end
         4'h7: begin nib = (ye & 32'h3800) ^ 32'h1000;
                     a = (((xe >> 9) & 32'h7c) ^ 32'h7c) + sb + ((ye >> 7) & 32'h180); end
         4'h8: begin b = ((ye >> 9) & 32'h3c) + sb; nib = (xe & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 8) & 32'h40) ^ 32'h40) + b; end
         4'h9: begin b = ((ye >> 9) & 32'h7c) + sb; nib = (xe & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 7) & 32'h180) ^ 32'h180) + b; end
         4'ha: begin nib = (ye & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 9) & 32'h3c) ^ 32'h3c) + sb + (((ye >> 8) & 32'h40) ^ 32'h40); end
         4'hb: begin nib = (ye & 32'h3800) ^ 32'h2800;
                     a = (((xe >> 9) & 32'h7c) ^ 32'h7c) + sb + (((ye >> 7) & 32'h180) ^ 32'h180); end
         4'hc: begin b = (((ye >> 9) & 32'h3c) ^ 32'h3c) + sb; nib = (xe & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 8) & 32'h40) + b; end
         4'hd: begin b = (((ye >> 9) & 32'h7c) ^ 32'h7c) + sb; nib = (xe & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 7) & 32'h180) + b; end
         4'he: begin nib = (ye & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 9) & 32'h3c) + sb + ((ye >> 8) & 32'h40); end
         default: begin nib = (ye & 32'h3800) ^ 32'h1000;
                     a = ((xe >> 9) & 32'h7c) + sb + ((ye >> 7) & 32'h180); end
      endcase
      st_addr = a[17:0] + {16'b0, nib[13:12]};
      st_lo   = nib[11];
   end

   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;         busy_in = busy_ff;
      ssize_in = ssize_ff;   map_base_in = map_base_ff; vcell_in = vcell_ff;
      img_start_in = img_start_ff; img_off_in = img_off_ff; hdot_in = hdot_ff;
      vdot_in = vdot_ff;     fn_in = fn_ff;
      line_y_in = line_y_ff; vp_in = vp_ff;           speed_in = speed_ff;
      acc_in = acc_ff;       map_addr_in = map_addr_ff; lines_in = lines_ff;
      count_in = count_ff;   col_in = col_ff;         buf_in = buf_ff;
      x_in = x_ff;  y_in = y_ff;  dx_in = dx_ff;  dy_in = dy_ff;
      vec_in = vec_ff;       k_in = k_ff;             entry_in = entry_ff;
      pix_in = pix_ff;       rd_in = rd_ff;           irq_in = irq_ff;
      ram_we = 1'b0; ram_wa = buf_addr; ram_wd = 8'd0; ram_ra = buf_addr;
      cmd_pop = 1'b0; rsp_push = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + 18'd1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_ra = cmd.ram_address;
            if (cmd_valid && rsp_room) begin
               cmd_pop  = 1'b1;
               rd_in    = 16'd0;
               irq_in   = 1'b0;
               state_in = ST_DONE;
               unique case (cmd.op)
                  OP_REG_WR: begin
                     unique case (reg_idx_type'(cmd.reg_index))
                        RI_STAMP_SIZE: begin ssize_in = cmd.write_data[2:0]; busy_in = 1'b0; end
                        RI_MAP_BASE:   map_base_in  = cmd.write_data & 16'hffe0;
                        RI_VCELL:      vcell_in     = cmd.write_data[4:0];
                        RI_IMG_START:  img_start_in = cmd.write_data & 16'hfff8;
                        RI_IMG_OFFSET: img_off_in   = cmd.write_data[5:0];
                        RI_HDOT:       hdot_in      = cmd.write_data[8:0];
                        RI_VDOT:       vdot_in      = cmd.write_data[7:0];
                        default: begin
                           if (!cfg.one_meg_mode) begin
                              // Job start: latch the function and the line setup.
                              fn_in       = {cfg.priority_mode, ssize_ff};
                              line_y_in   = {13'd0, img_off_ff[5:3]};
                              vp_in       = {cmd.write_data[15:1], 4'b0} >> 1;
                              speed_in    = SPEED_TABLE[hdot_ff[8:3]];
                              acc_in      = {12'd0, SPEED_TABLE[hdot_ff[8:3]]};
                              busy_in     = 1'b1;
                              map_addr_in = map_start;
                              state_in    = ST_RUN;
                           end
                        end
                     endcase
                  end
                  OP_REG_RD: begin
                     unique case (reg_idx_type'(cmd.reg_index))
                        RI_STAMP_SIZE: rd_in = {busy_ff, 12'd0, ssize_ff};
                        RI_MAP_BASE:   rd_in = map_base_ff;
                        RI_VCELL:      rd_in = {11'd0, vcell_ff};
                        RI_IMG_START:  rd_in = img_start_ff;
                        RI_IMG_OFFSET: rd_in = {10'd0, img_off_ff};
                        RI_HDOT:       rd_in = {7'd0, hdot_ff};
                        RI_VDOT:       rd_in = {8'd0, vdot_ff};
                        default:       rd_in = 16'd0;
                     endcase
                  end
                  OP_RAM_WR: begin
                     ram_we = 1'b1;
                     ram_wa = cmd.ram_address;
                     ram_wd = cmd.write_data[7:0];
                  end
                  OP_RAM_RD: state_in = ST_RAMRD;
                  OP_TICK: begin
                     if (busy_ff) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RAMRD: begin
            rd_in    = {8'd0, rdata_ff};
            state_in = ST_DONE;
         end
         ST_RUN: begin
            if (vdot_ff == 8'd0) begin
               busy_in  = 1'b0;
               irq_in   = cfg.irq_enable;
               state_in = ST_DONE;
            end else if (acc_ff[31:16] == 16'd0) begin
               acc_in   = acc_ff + {12'd0, speed_ff};
               state_in = ST_DONE;
            end else begin
               acc_in   = {16'd0, acc_ff[15:0]} + {12'd0, speed_ff};
               lines_in = acc_ff[31:16];
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            count_in = hdot_ff;
            col_in   = img_off_ff[2:0];
            buf_in   = {img_start_ff + line_y_ff, 2'b00};
            k_in     = 4'd0;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            ram_ra = vp_ff[17:0] + {14'd0, k_ff};
            if (k_ff != 4'd0) begin
               vec_in = vec_next;
            end
            if (k_ff == 4'd8) begin
               x_in     = {vec_next[15:0], 8'd0};
               y_in     = {vec_next[31:16], 8'd0};
               dx_in    = {{8{vec_next[47]}}, vec_next[47:32]};
               dy_in    = {{8{vec_next[63]}}, vec_next[63:48]};
               vp_in    = vp_ff + 19'd8;
               state_in = ST_PIX;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         ST_PIX: begin
            ram_ra = map_rd;
            if (count_ff == 9'd0) begin
               line_y_in = line_y_ff + 16'd1;
               if (vdot_ff == 8'd1) begin
                  vdot_in  = 8'd0;
                  busy_in  = 1'b0;
                  irq_in   = cfg.irq_enable;
                  state_in = ST_DONE;
               end else begin
                  vdot_in  = vdot_ff - 8'd1;
                  lines_in = lines_ff - 16'd1;
                  state_in = (lines_ff == 16'd1) ? ST_DONE : ST_LINE;
               end
            end else if (clipped) begin
               pix_in   = 4'd0;
               state_in = prio_on ? ST_ADV : ST_BUF0;
            end else begin
               state_in = ST_MAP1;
            end
         end
         ST_MAP1: begin
            ram_ra   = map_rd + 18'd1;
            entry_in = {entry_ff[15:8], rdata_ff};
            state_in = ST_MAP2;
         end
         ST_MAP2: begin
            entry_in = {rdata_ff, entry_ff[7:0]};
            state_in = ST_STAMP0;
         end
         ST_STAMP0: begin
            ram_ra = st_addr;
            if (entry_ff[10:0] == 11'd0) begin
               pix_in   = 4'd0;
               state_in = prio_on ? ST_ADV : ST_BUF0;
            end else begin
               state_in = ST_STAMP1;
            end
         end
         ST_STAMP1: begin
            pix_in   = st_lo ? rdata_ff[3:0] : rdata_ff[7:4];
            state_in = ((pix_in == 4'd0) && prio_on) ? ST_ADV : ST_BUF0;
         end
         ST_BUF0: begin
            state_in = ST_BUF1;
         end
         ST_BUF1: begin
            // Underwrite mode keeps a nibble that is already set.
            if (col_ff[0]) begin
               ram_we = !((rdata_ff[3:0] != 4'd0) && (fn_ff[4:3] == 2'd1));
               ram_wd = {rdata_ff[7:4], pix_ff};
            end else begin
               ram_we = !((rdata_ff[7:4] != 4'd0) && (fn_ff[4:3] == 2'd1));
               ram_wd = {pix_ff, rdata_ff[3:0]};
            end
            state_in = ST_ADV;
         end
         ST_ADV: begin
            x_in     = x_ff + dx_ff;
            y_in     = y_ff + dy_ff;
            count_in = count_ff - 9'd1;
            col_in   = col_ff + 3'd1;
            if (col_ff == 3'd7) begin
               buf_in = buf_ff + cell_step;
            end
            state_in = ST_PIX;
         end
         default: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp      = '{read_data: rd_ff, busy_res: busy_ff, irq_pulse: irq_ff};
   assign clearing = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;  clr_ff <= 18'd0;     busy_ff <= 1'b0;
         ssize_ff <= 3'd0;      map_base_ff <= 16'd0; vcell_ff <= 5'd0;
         img_start_ff <= 16'd0; img_off_ff <= 6'd0;  hdot_ff <= 9'd0;
         vdot_ff <= 8'd0;       fn_ff <= 5'd0;
         line_y_ff <= 16'd0;    vp_ff <= 19'd0;      speed_ff <= 20'd0;
         acc_ff <= 32'd0;       map_addr_ff <= 18'd0; irq_ff <= 1'b0;
         rd_ff <= 16'd0;
      end else begin
         state_ff <= state_in;  clr_ff <= clr_in;    busy_ff <= busy_in;
         ssize_ff <= ssize_in;  map_base_ff <= map_base_in; vcell_ff <= vcell_in;
         img_start_ff <= img_start_in; img_off_ff <= img_off_in; hdot_ff <= hdot_in;
         vdot_ff <= vdot_in;    fn_ff <= fn_in;
         line_y_ff <= line_y_in; vp_ff <= vp_in;     speed_ff <= speed_in;
         acc_ff <= acc_in;      map_addr_ff <= map_addr_in; irq_ff <= irq_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      lines_ff <= lines_in;  count_ff <= count_in;  col_ff <= col_in;
      buf_ff <= buf_in;      x_ff <= x_in;          y_ff <= y_in;
      dx_ff <= dx_in;        dy_ff <= dy_in;        vec_ff <= vec_in;
      k_ff <= k_in;          entry_ff <= entry_in;  pix_ff <= pix_in;
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_wa] <= ram_wd;
      end
      rdata_ff <= ram_mem[ram_ra];
   end

endmodule

### hw/rtl/stamp_rotation_renderer.sv
// Top level of the stamp rotation renderer: configuration registers, the
// result queue and the front and back ends. Depends on srr_pkg, srr_front, srr_back.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_push / req_full     req_data  (req_type)
//   rsp_*     out        rsp_pop / rsp_empty     rsp_data  (rsp_type)
//   csr_*     in/out     APB psel/penable/pready pwdata / prdata, paddr[3:2] selects
//
// After reset the word RAM is zeroed one byte per cycle, all 262144 bytes;
// req_full stays high during that pass, while csr_* writes are still taken.
// The back end carries out one command at a time. A tick that draws lines
// fetches each line's vector, then reads map, stamp and buffer per pixel,
// all through the single word RAM read port that serves vector, map, stamp and buffer.
// Up to two requests queue ahead of the back end and two results behind it.
module stamp_rotation_renderer import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] CSR_PRIORITY = 2'd0;
   localparam logic [1:0] CSR_ONE_MEG  = 2'd1;
   localparam logic [1:0] CSR_IRQ_EN   = 2'd2;

   cfg_type    cfg_ff, cfg_in;
   logic       cmd_valid, cmd_pop, rsp_push, clearing;
   cmd_type    cmd;
   rsp_type    rsp;
   rsp_type    oq_ff [2];
   logic       owp_ff, orp_ff;
   logic [1:0] ocnt_ff, ocnt_in;
   logic       csr_wr, out_take;

   // Configuration registers; a write completes on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         priority case (csr_paddr[3:2])
            CSR_PRIORITY: cfg_in.priority_mode = csr_pwdata[1:0];
            CSR_ONE_MEG:  cfg_in.one_meg_mode  = csr_pwdata[0];
            CSR_IRQ_EN:   cfg_in.irq_enable    = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
      priority case (csr_paddr[3:2])
         CSR_PRIORITY: csr_prdata = {30'd0, cfg_ff.priority_mode};
         CSR_ONE_MEG:  csr_prdata = {31'd0, cfg_ff.one_meg_mode};
         CSR_IRQ_EN:   csr_prdata = {31'd0, cfg_ff.irq_enable};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   srr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (ocnt_ff != 2'd2),
      .rsp_push  (rsp_push),
      .rsp       (rsp),
      .clearing  (clearing)
   );

   // Two-entry result queue so the back end never waits on a slow consumer
   // for the result it has just finished.
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = oq_ff[orp_ff];
   assign out_take  = rsp_pop && !rsp_empty;
   assign ocnt_in   = ocnt_ff + {1'b0, rsp_push} - {1'b0, out_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= 1'b0;
         orp_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         owp_ff  <= owp_ff ^ rsp_push;
         orp_ff  <= orp_ff ^ out_take;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         oq_ff[owp_ff] <= rsp;
      end
   end

endmodule

### hw/rtl/srr_checker.sv
// Port-level checks of the stamp rotation renderer, bound to its top level.
// Depends on srr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srr_checker import srr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input rsp_type     rsp_data,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata
);

   logic irq_en_ff;

   // Shadow of the interrupt enable, as written through the register port.
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[3:2] == 2'd2)) begin
         irq_en_ff <= csr_pwdata[0];
      end
   end

   `CHK_ASSERT(a_empty_after_reset, clock, reset, $past(reset) |-> rsp_empty, "result queue not empty after reset")
   `CHK_ASSERT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "waiting result changed")
   `CHK_ASSERT(a_irq_enabled, clock, reset, (!rsp_empty && rsp_data.irq_pulse) |-> irq_en_ff, "interrupt without enable")
   `CHK_ASSERT(a_irq_idle, clock, reset, (!rsp_empty && rsp_data.irq_pulse) |-> !rsp_data.busy_res, "interrupt while still busy")

endmodule

bind stamp_rotation_renderer srr_checker u_srr_checker (.*);
